[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[sv/rn2a_pkg.sv]
// types and constants for the radix number to ascii block
`timescale 1ns / 1ps
package rn2a_pkg;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned RADIX_W = 5;
	localparam logic [CHAR_W-1:0] CHAR_MIN = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_MAX = 8'd126;
	localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2b;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_X = 8'h78;
	localparam logic [1:0] REG_RADIX = 2'd0;
	localparam logic [1:0] REG_CHARS_LOW = 2'd1;
	localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_EMIT,
		ST_ERROR
	} state_t;

	// control from the sequencer to the divider chain
	typedef struct packed {
		logic load;
		logic shift;
		logic restart;
	} chain_ctrl_t;
endpackage

[sv/rn2a_cell.sv]
// one cell of the divider chain: holds one bit, loaded from the value or shifted on
`timescale 1ns / 1ps
module rn2a_cell (
	input  logic clk,
	input  rn2a_pkg::chain_ctrl_t ctrl,
	input  logic load_bit,
	input  logic quot_bit,
	output logic bit_q
);
	import rn2a_pkg::*;

	// each cell holds a value bit and shifts in the next lower one; cell 0 gets qbit
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bit_q <= load_bit;
		end else if (ctrl.shift) begin
			bit_q <= quot_bit;
		end
	end
endmodule

[sv/rn2a_divider.sv]
// bit-serial divider: a chain of cells shifting the dividend into a remainder register
`timescale 1ns / 1ps
module rn2a_divider #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic clk,
	input  rn2a_pkg::chain_ctrl_t ctrl,
	input  logic [VALUE_BITS-1:0] load_value,
	input  logic [rn2a_pkg::RADIX_W-1:0] radix,
	output logic [VALUE_BITS-1:0] value,
	output logic [rn2a_pkg::DIGIT_W-1:0] remainder
);
	import rn2a_pkg::*;

	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic qbit;
	logic [VALUE_BITS-1:0] next_bits;

	// msb of the chain shifts into the partial remainder
	assign trial = {rem_q, value[VALUE_BITS-1]};
	assign diff = trial - {1'b0, radix};
	assign qbit = !diff[RADIX_W];
	assign next_bits = {value[VALUE_BITS-2:0], qbit};

	genvar gi;
	generate
		for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cell
			rn2a_cell u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.load_bit(load_value[gi]),
				.quot_bit(next_bits[gi]),
				.bit_q(value[gi])
			);
		end
	endgenerate

	// remainder starts from zero for every digit
	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.restart) begin
			rem_q <= '0;
		end else if (ctrl.shift) begin
			rem_q <= qbit ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign remainder = rem_q[DIGIT_W-1:0];
endmodule

[sv/radix_number_to_ascii_top.sv]
// top level: config registers, table check, digit sequencer and output pairs
//
// Converts one 64-bit value at a time to "0x" and its digits in the
// configured radix, two characters per output beat. After the accept cycle
// the table check visits each used character in turn (up to 16; a bad
// radix goes straight to the error beat), each digit is worked out in
// the bit-serial divider chain, each output pair waits until the
// receiver takes it, and the block passes through idle before the next
// accept; a new value is taken only once the last beat of the previous
// one has gone out.
`timescale 1ns / 1ps
module radix_number_to_ascii_top #(
	parameter int unsigned VALUE_BITS = 64,
	parameter int unsigned MAX_RADIX = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [63:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] first_char,
	output logic [7:0] second_char,
	output logic second_valid,
	output logic last,
	output logic [6:0] total_count,
	output logic base_error
);
	import rn2a_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS + 1);

	logic [RADIX_W-1:0] radix_q;
	logic [63:0] chars_low_q;
	logic [63:0] chars_high_q;
	logic [1:0] reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			chars_low_q <= '0;
			chars_high_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RADIX: radix_q <= pwdata[RADIX_W-1:0];
				REG_CHARS_LOW: chars_low_q <= pwdata;
				REG_CHARS_HIGH: chars_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RADIX: prdata = {59'd0, radix_q};
			REG_CHARS_LOW: prdata = chars_low_q;
			REG_CHARS_HIGH: prdata = chars_high_q;
			default: prdata = '0;
		endcase
	end

	function automatic logic [CHAR_W-1:0] tchar(input logic [127:0] t, input logic [3:0] i);
		return t[i*8 +: 8];
	endfunction

	logic [127:0] table_w;
	assign table_w = {chars_high_q, chars_low_q};

	state_t state_q, state_d;
	logic [3:0] chk_q;
	logic bad_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic [COUNT_W-1:0] ndig_q;
	logic [5:0] rd_q;
	logic [5:0] rd_d;
	logic [5:0] pair_q;
	logic [DIGIT_W-1:0] dbuf [64];
	logic [DIGIT_W-1:0] dig_a_q;
	logic [DIGIT_W-1:0] dig_b_q;
	logic [VALUE_BITS-1:0] dvalue;
	logic [DIGIT_W-1:0] drem;
	chain_ctrl_t ctrl;
	logic [COUNT_W-1:0] total;
	logic [CHAR_W-1:0] cur_char, ochar_a, ochar_b;
	logic [6:0] pos_a;
	logic [RADIX_W-1:0] rad_eff;
	logic chk_bad, digit_done, pair_last;

	assign rad_eff = radix_q;
	assign total = ndig_q + COUNT_W'(2);

	// check character chk_q against range, signs and every later used char
	always_comb begin
		logic [CHAR_W-1:0] c;
		c = tchar(table_w, chk_q);
		chk_bad = (c < CHAR_MIN) || (c > CHAR_MAX) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
		for (int j = 0; j < 16; j++) begin
			if ((j > 32'(chk_q)) && (j < 32'(rad_eff)) && (tchar(table_w, 4'(j)) == c)) begin
				chk_bad = 1'b1;
			end
		end
	end

	assign digit_done = (bit_q == BIT_CNT_W'(VALUE_BITS));

	// characters of the current pair: index a is 2*pair, b is a+1
	assign pos_a = {pair_q, 1'b0};
	function automatic logic [CHAR_W-1:0] text_char(input logic [6:0] p,
			input logic [CHAR_W-1:0] dc);
		if (p == 7'd0) return CHAR_ZERO;
		if (p == 7'd1) return CHAR_X;
		return dc;
	endfunction

	// rd_q points at the digit for the first char of the pair on show
	always_comb begin
		rd_d = rd_q;
		if ((state_q == ST_DIVIDE) && digit_done) begin
			rd_d = ndig_q[5:0];
		end else if ((state_q == ST_EMIT) && out_ready && (pair_q != 6'd0)) begin
			rd_d = rd_q - 6'd2;
		end
	end

	logic [CHAR_W-1:0] dchar_a, dchar_b;
	assign dchar_a = tchar(table_w, dig_a_q);
	assign dchar_b = tchar(table_w, dig_b_q);
	assign ochar_a = text_char(pos_a, dchar_a);
	assign ochar_b = text_char(pos_a + 7'd1, (pos_a == 7'd0) ? CHAR_X : dchar_b);
	assign pair_last = (pos_a + 7'd2) >= 7'(total);
	assign cur_char = ochar_a;

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if ((rad_eff < 5'd2) || (rad_eff > RADIX_W'(MAX_RADIX)) || bad_q) begin
					state_d = ST_ERROR;
				end else if (chk_bad) begin
					state_d = ST_ERROR;
				end else if ({1'b0, chk_q} + 5'd1 >= rad_eff) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (!digit_done) begin
					ctrl.shift = 1'b1;
				end else begin
					ctrl.restart = 1'b1;
					if ((dvalue == '0) || (ndig_q == COUNT_W'(63))) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && pair_last) state_d = ST_IDLE;
			end
			ST_ERROR: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= '0;
			bad_q <= 1'b0;
			bit_q <= '0;
			ndig_q <= '0;
			rd_q <= '0;
			pair_q <= '0;
		end else begin
			rd_q <= rd_d;
			case (state_q)
				ST_IDLE: begin
					chk_q <= '0;
					bad_q <= 1'b0;
					bit_q <= '0;
					ndig_q <= '0;
					pair_q <= '0;
				end
				ST_CHECK: begin
					chk_q <= chk_q + 4'd1;
				end
				ST_DIVIDE: begin
					if (!digit_done) begin
						bit_q <= bit_q + BIT_CNT_W'(1);
					end else begin
						ndig_q <= ndig_q + COUNT_W'(1);
						bit_q <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						pair_q <= pair_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// registered read of the two digits of the pair that shows next
	always_ff @(posedge clk) begin
		if (state_q == ST_DIVIDE && digit_done) begin
			dbuf[ndig_q[5:0]] <= drem;
		end
		dig_a_q <= dbuf[rd_d];
		dig_b_q <= dbuf[rd_d - 6'd1];
	end

	// chain restarts from the quotient after each digit
	rn2a_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk(clk),
		.ctrl(ctrl),
		.load_value(value[VALUE_BITS-1:0]),
		.radix(rad_eff),
		.value(dvalue),
		.remainder(drem)
	);

	logic has2;
	assign has2 = (pos_a + 7'd1) < 7'(total);
	assign first_char = (state_q == ST_ERROR) ? '0 : cur_char;
	assign second_char = (state_q == ST_ERROR || !has2) ? '0 : ochar_b;
	assign second_valid = (state_q == ST_EMIT) && has2;
	assign last = (state_q == ST_ERROR) || pair_last;
	assign total_count = (state_q == ST_EMIT && pair_last) ? total : '0;
	assign base_error = (state_q == ST_ERROR);

	`ASSERT_ALWAYS(a_err_one, clk, arst_n, !(out_valid && base_error) || (last && total_count == '0), "error beat malformed")
	`ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && last, state_q == ST_IDLE, "not idle after last beat")
	`ASSERT_ALWAYS(a_no_take, clk, arst_n, !(in_ready && out_valid), "input taken during output")
endmodule
